[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks used by the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[src/tdrmq_pkg.sv]
// ----------------------------------------------------------------------------
// Tree distance range-minimum package
// Shared types and constants for the tree distance query core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tdrmq_pkg;
   localparam int MaxVertices = 1024;
   localparam int TourLength  = 2048;
   localparam int VtxW  = $clog2(MaxVertices);
   localparam int PosW  = $clog2(TourLength);
   localparam int IdxW  = 11;
   localparam int DepW  = 31;
   localparam logic [30:0] UnreachReset = 31'd1061109567;

   localparam logic [1:0] ACT_LOAD_DEPTH = 2'd0;
   localparam logic [1:0] ACT_LOAD_POS   = 2'd1;
   localparam logic [1:0] ACT_QUERY      = 2'd2;
   localparam logic [1:0] ACT_UNUSED     = 2'd3;

   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_UNREACHABLE  = 1'b1;

   typedef struct packed {
      logic [1:0]      action;
      logic [IdxW-1:0] first_index;
      logic [IdxW-1:0] second_index;
      logic [DepW-1:0] depth_value;
   } req_type;

   typedef struct packed {
      logic [DepW-1:0] tree_distance;
      logic            is_unreachable;
   } rsp_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      logic            is_query;
      logic            is_depth;
      logic            fail;
      logic [IdxW-1:0] first_index;
      logic [IdxW-1:0] second_index;
      logic [DepW-1:0] depth_value;
   } cmd_type;
endpackage

[src/tdrmq_front.sv]
// ----------------------------------------------------------------------------
// Tree distance front end
// Accepts items, drops unused ones and checks query vertex ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tdrmq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tdrmq_pkg::req_type    req_data,
   input  logic [10:0]           vertex_count,
   output logic                  cmd_valid,
   input  logic                  cmd_stall,
   output tdrmq_pkg::cmd_type    cmd_data
);
   logic                 cmd_valid_ff, cmd_valid_in;
   tdrmq_pkg::cmd_type   cmd_ff, cmd_in;
   logic                 take;
   logic                 a_bad, b_bad;

   assign req_stall = cmd_valid_ff && cmd_stall;
   assign take      = req_valid && !req_stall;

   always_comb begin
      a_bad = ({1'b0, req_data.first_index} >= {1'b0, vertex_count}) ||
              ({1'b0, req_data.first_index} >= 12'(tdrmq_pkg::MaxVertices));
      b_bad = ({1'b0, req_data.second_index} >= {1'b0, vertex_count}) ||
              ({1'b0, req_data.second_index} >= 12'(tdrmq_pkg::MaxVertices));
      cmd_in.is_query     = req_data.action == tdrmq_pkg::ACT_QUERY;
      cmd_in.is_depth     = req_data.action == tdrmq_pkg::ACT_LOAD_DEPTH;
      cmd_in.fail         = a_bad || b_bad;
      cmd_in.first_index  = req_data.first_index;
      cmd_in.second_index = req_data.second_index;
      cmd_in.depth_value  = req_data.depth_value;
      cmd_valid_in = cmd_valid_ff;
      if (take) begin
         cmd_valid_in = (req_data.action != tdrmq_pkg::ACT_UNUSED);
      end else if (!cmd_stall) begin
         cmd_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd_data  = cmd_ff;
endmodule

[src/tdrmq_fifo.sv]
// ----------------------------------------------------------------------------
// Tree distance command queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tdrmq_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  tdrmq_pkg::cmd_type    in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output tdrmq_pkg::cmd_type    out_data
);
   tdrmq_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_stall  = count_ff == 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

[src/tdrmq_back.sv]
// ----------------------------------------------------------------------------
// Tree distance back end
// Owns both stores, performs loads and walks the tour range for queries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tdrmq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_stall,
   input  tdrmq_pkg::cmd_type    cmd_data,
   input  logic [30:0]           unreach,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tdrmq_pkg::rsp_type    rsp_data,
   output logic                  busy
);
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_POSA  = 8'b0000_0010,
      ST_POSB  = 8'b0000_0100,
      ST_DEPA  = 8'b0000_1000,
      ST_DEPB  = 8'b0001_0000,
      ST_SCAN  = 8'b0010_0000,
      ST_CALC  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   logic [30:0] depth_mem [tdrmq_pkg::TourLength];
   logic [10:0] pos_mem   [tdrmq_pkg::MaxVertices];

   state_type   state_ff, state_in;
   logic [30:0] dep_rd_ff;
   logic [10:0] pos_rd_ff;
   logic [tdrmq_pkg::PosW-1:0] dep_addr;
   logic [tdrmq_pkg::VtxW-1:0] pos_addr;
   logic [10:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [30:0] da_ff, da_in, db_ff, db_in, min_ff, min_in;
   logic [tdrmq_pkg::PosW-1:0] cur_ff, cur_in, hi_ff, hi_in;
   logic        first_ff, first_in, fail_ff, fail_in;
   tdrmq_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        cmd_take;
   logic signed [33:0] diff;
   logic [tdrmq_pkg::PosW-1:0] lo_pos, hi_pos;

   assign cmd_stall = (state_ff != ST_IDLE);
   assign cmd_take  = cmd_valid && !cmd_stall;
   assign busy      = (state_ff != ST_IDLE) || rsp_valid_ff;

   always_comb begin
      lo_pos = (pa_ff < pb_ff) ? pa_ff[tdrmq_pkg::PosW-1:0] : pb_ff[tdrmq_pkg::PosW-1:0];
      hi_pos = (pa_ff < pb_ff) ? pb_ff[tdrmq_pkg::PosW-1:0] : pa_ff[tdrmq_pkg::PosW-1:0];
      diff = 34'($signed({3'b0, da_ff})) + 34'($signed({3'b0, db_ff}))
           - 34'($signed({2'b0, min_ff, 1'b0}));
      pos_addr = cmd_data.first_index[tdrmq_pkg::VtxW-1:0];
      dep_addr = cur_ff;
      case (state_ff)
         ST_POSB: pos_addr = pb_ff[tdrmq_pkg::VtxW-1:0];
         ST_DEPA: dep_addr = pa_ff[tdrmq_pkg::PosW-1:0];
         ST_DEPB: dep_addr = pb_ff[tdrmq_pkg::PosW-1:0];
         // The address runs one slot ahead of the depth being compared.
         ST_SCAN: dep_addr = first_ff ? cur_ff : cur_ff + 1'b1;
         default: ;
      endcase
      state_in = state_ff; pa_in = pa_ff; pb_in = pb_ff; da_in = da_ff;
      db_in = db_ff; min_in = min_ff; cur_in = cur_ff; hi_in = hi_ff;
      first_in = first_ff; fail_in = fail_ff; rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_take && cmd_data.is_query) begin
               pb_in = cmd_data.second_index;
               fail_in = cmd_data.fail;
               state_in = cmd_data.fail ? ST_CALC : ST_POSA;
            end
         end
         ST_POSA: begin
            // The vertex a position lands now; vertex b's is read next.
            pa_in = pos_rd_ff;
            state_in = ST_POSB;
         end
         ST_POSB: state_in = ST_DEPA;
         ST_DEPA: begin
            // An 11-bit position always lies inside the tour.
            pb_in = pos_rd_ff;
            state_in = ST_DEPB;
         end
         ST_DEPB: begin
            da_in = dep_rd_ff;
            cur_in = lo_pos;
            hi_in = hi_pos;
            first_in = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Read data is registered and arrives in the cycle after its address.
            if (first_ff) begin
               db_in = dep_rd_ff;
               first_in = 1'b0;
               min_in = '1;
               cur_in = cur_ff;
               if (da_ff == unreach || dep_rd_ff == unreach) begin
                  fail_in = 1'b1;
                  state_in = ST_CALC;
               end
            end
         end
         default: ;
      endcase
      if (state_ff == ST_SCAN && !first_ff) begin
         if (dep_rd_ff < min_ff) min_in = dep_rd_ff;
         if (cur_ff == hi_ff) state_in = ST_CALC;
         else cur_in = cur_ff + 1'b1;
      end
      if (state_ff == ST_SCAN && first_ff && !(da_ff == unreach ||
          dep_rd_ff == unreach)) begin
         cur_in = cur_ff;
         first_in = 1'b0;
      end
      if (state_ff == ST_CALC && !rsp_valid_ff) begin
         rsp_valid_in = 1'b1;
         state_in = ST_IDLE;
         if (fail_ff) begin
            rsp_in.tree_distance = unreach; rsp_in.is_unreachable = 1'b1;
         end else if (diff < 0) begin
            rsp_in.tree_distance = '0; rsp_in.is_unreachable = 1'b0;
         end else if (diff > 34'sh7FFF_FFFF) begin
            rsp_in.tree_distance = unreach; rsp_in.is_unreachable = 1'b0;
         end else begin
            rsp_in.tree_distance = diff[30:0]; rsp_in.is_unreachable = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pa_ff <= pa_in; pb_ff <= pb_in; da_ff <= da_in; db_ff <= db_in;
      min_ff <= min_in; cur_ff <= cur_in; hi_ff <= hi_in;
      first_ff <= first_in; fail_ff <= fail_in; rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd_take && cmd_data.is_depth &&
          {1'b0, cmd_data.first_index} < 12'(tdrmq_pkg::TourLength)) begin
         depth_mem[cmd_data.first_index[tdrmq_pkg::PosW-1:0]] <= cmd_data.depth_value;
      end
      dep_rd_ff <= depth_mem[dep_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd_take && !cmd_data.is_depth && !cmd_data.is_query &&
          {1'b0, cmd_data.first_index} < 12'(tdrmq_pkg::MaxVertices)) begin
         pos_mem[cmd_data.first_index[tdrmq_pkg::VtxW-1:0]] <= cmd_data.second_index;
      end
      pos_rd_ff <= pos_mem[pos_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[src/tree_distance_range_min_query_core.sv]
// ----------------------------------------------------------------------------
// Tree distance range-minimum query core
// Tree distance between vertices over an Euler tour with range minimum.
// ----------------------------------------------------------------------------
// Usage: the req channel (valid/stall) carries loads of tour depths, loads of
// vertex positions and distance queries; the rsp channel returns one beat per
// query. csr_ writes set vertex_count (index 0) and unreachable_value (1).
// An accepted load passes the front-end register and the queue before the back
// end writes it to its store. A query walks the tour range one slot per cycle
// in the back end, using one read port of the depth memory; the back end takes
// no new command until the query has finished. Out-of-range queries skip the
// tour walk. The queue between front and back holds two commands, so loads can
// still be accepted while a query scans, until the queue fills.
// Reset (synchronous, active high) resets control state and the CSR registers;
// memories keep their contents and are undefined until written.
// While rsp_stall is high the result holds and the back end waits; the
// queue fills and then req_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tree_distance_range_min_query_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tdrmq_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tdrmq_pkg::rsp_type  rsp_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [30:0]         csr_data
);
   logic [10:0] vcount_ff;
   logic [30:0] unreach_ff;
   logic fv, fs, qv, qs, busy;
   tdrmq_pkg::cmd_type fcmd, qcmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff  <= '0;
         unreach_ff <= tdrmq_pkg::UnreachReset;
      end else if (csr_write) begin
         case (csr_index)
            tdrmq_pkg::CSR_VERTEX_COUNT: vcount_ff  <= csr_data[10:0];
            tdrmq_pkg::CSR_UNREACHABLE:  unreach_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tdrmq_front u_front (.clock, .reset, .req_valid, .req_stall, .req_data,
      .vertex_count(vcount_ff), .cmd_valid(fv), .cmd_stall(fs), .cmd_data(fcmd));
   tdrmq_fifo u_fifo (.clock, .reset, .in_valid(fv), .in_stall(fs), .in_data(fcmd),
      .out_valid(qv), .out_stall(qs), .out_data(qcmd));
   tdrmq_back u_back (.clock, .reset, .cmd_valid(qv), .cmd_stall(qs), .cmd_data(qcmd),
      .unreach(unreach_ff), .rsp_valid, .rsp_stall, .rsp_data, .busy);

   `ASSERT_IMPL(a_fail_marker, clock, reset, rsp_valid && rsp_data.is_unreachable, rsp_data.tree_distance == unreach_ff)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPL(a_busy_rsp, clock, reset, rsp_valid, busy)
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Tree distance range-minimum query core testbench
// Loads Euler tours and vertex positions, runs distance queries under random
// idling and stalls on both sides, and checks every result beat against an
// internal model of the two stores and the two registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
   localparam logic [30:0] DEPTH_MAX  = 31'h7FFF_FFFF;
   localparam int          DIRECTED_ROWS = 22;
   localparam int          RANDOM_ITEMS  = 500;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic               csr_idx;
      logic [30:0]        csr_val;
      tdrmq_pkg::req_type beat;
      logic               typed;
      tdrmq_pkg::rsp_type result;
   } stim_row_type;

   logic    clock, reset;
   logic    req_valid, req_stall;
   tdrmq_pkg::req_type req_data;
   logic    rsp_valid, rsp_stall;
   tdrmq_pkg::rsp_type rsp_data;
   logic    csr_write, csr_index;
   logic [30:0] csr_data;

   // Model state mirrored from the accepted beats.
   logic [30:0] depth_mem [tdrmq_pkg::TourLength];
   logic [10:0] pos_mem   [tdrmq_pkg::MaxVertices];
   bit          depth_set [tdrmq_pkg::TourLength];
   bit          pos_set   [tdrmq_pkg::MaxVertices];
   logic [10:0] vertex_limit;
   logic [30:0] marker;

   tdrmq_pkg::rsp_type pending_distances[$];
   int      error_count;
   bit      idle_on;
   int      rsp_hold;

   tree_distance_range_min_query_core uut (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .csr_write, .csr_index, .csr_data
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tree_distance_range_min_query_core test failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic tdrmq_pkg::rsp_type tree_distance_of(input logic [10:0] a,
                                                           input logic [10:0] b);
      tdrmq_pkg::rsp_type r;
      logic [10:0] pa, pb, lo, hi;
      logic [30:0] m;
      longint      d;
      r.tree_distance  = marker;
      r.is_unreachable = 1'b1;
      if (a >= vertex_limit || b >= vertex_limit ||
          a >= tdrmq_pkg::MaxVertices || b >= tdrmq_pkg::MaxVertices)
         return r;
      pa = pos_mem[a];
      pb = pos_mem[b];
      if (depth_mem[pa] == marker || depth_mem[pb] == marker) return r;
      lo = (pa < pb) ? pa : pb;
      hi = (pa < pb) ? pb : pa;
      m = depth_mem[lo];
      for (int i = lo + 1; i <= hi; i++)
         if (depth_mem[i] < m) m = depth_mem[i];
      d = longint'(depth_mem[pa]) + longint'(depth_mem[pb]) - 2 * longint'(m);
      r.is_unreachable = 1'b0;
      if (d < 0) r.tree_distance = '0;
      else if (d > longint'(DEPTH_MAX)) r.tree_distance = marker;
      else r.tree_distance = d[30:0];
      return r;
   endfunction

   // A query must never read a store entry that was not written since reset.
   function automatic bit query_is_defined(input logic [10:0] a, input logic [10:0] b);
      logic [10:0] pa, pb, lo, hi;
      if (a >= vertex_limit || b >= vertex_limit ||
          a >= tdrmq_pkg::MaxVertices || b >= tdrmq_pkg::MaxVertices)
         return 1;
      if (!pos_set[a] || !pos_set[b]) return 0;
      pa = pos_mem[a];
      pb = pos_mem[b];
      if (!depth_set[pa] || !depth_set[pb]) return 0;
      if (depth_mem[pa] == marker || depth_mem[pb] == marker) return 1;
      lo = (pa < pb) ? pa : pb;
      hi = (pa < pb) ? pb : pa;
      for (int i = lo; i <= hi; i++)
         if (!depth_set[i]) return 0;
      return 1;
   endfunction

   task automatic apply_beat(input tdrmq_pkg::req_type r, input bit typed,
                             input tdrmq_pkg::rsp_type result);
      case (r.action)
         tdrmq_pkg::ACT_LOAD_DEPTH: begin
            depth_mem[r.first_index] = r.depth_value;
            depth_set[r.first_index] = 1;
         end
         tdrmq_pkg::ACT_LOAD_POS: begin
            if (r.first_index < tdrmq_pkg::MaxVertices) begin
               pos_mem[r.first_index] = r.second_index;
               pos_set[r.first_index] = 1;
            end
         end
         tdrmq_pkg::ACT_QUERY: begin
            if (typed) pending_distances = {pending_distances, result};
            else pending_distances = {pending_distances,
                                      tree_distance_of(r.first_index, r.second_index)};
         end
         default: ;
      endcase
   endtask

   task automatic send_beat(input tdrmq_pkg::req_type r, input bit typed = 0,
                            input tdrmq_pkg::rsp_type result = '0);
      int gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      apply_beat(r, typed, result);
   endtask

   // Waits for every expected result, then lets any load still in flight land.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [30:0] value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == tdrmq_pkg::CSR_VERTEX_COUNT) vertex_limit = value[10:0];
      else marker = value;
   endtask

   function automatic tdrmq_pkg::req_type make_beat(input logic [1:0] act,
                                                    input logic [10:0] f,
                                                    input logic [10:0] s,
                                                    input logic [30:0] d);
      tdrmq_pkg::req_type r;
      r.action = act;
      r.first_index = f;
      r.second_index = s;
      r.depth_value = d;
      return r;
   endfunction

   // Result channel: checks each beat and draws a stall before the next one.
   always @(posedge clock) begin
      int gap_draw;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (pending_distances.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_data.tree_distance, 0);
         end else begin
            tdrmq_pkg::rsp_type want;
            want = pending_distances.pop_front();
            if (rsp_data.tree_distance !== want.tree_distance)
               report_mismatch("tree_distance", rsp_data.tree_distance, want.tree_distance);
            if (rsp_data.is_unreachable !== want.is_unreachable)
               report_mismatch("is_unreachable", rsp_data.is_unreachable, want.is_unreachable);
         end
         gap_draw  = idle_on ? $urandom_range(0, 3) : 0;
         rsp_hold  <= (gap_draw > 0) ? gap_draw - 1 : 0;
         rsp_stall <= (gap_draw > 0);
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   stim_row_type directed[DIRECTED_ROWS];

   task automatic add_row(inout int n, input row_kind_type kind, input tdrmq_pkg::req_type r,
                          input logic idx = 0, input logic [30:0] v = 0,
                          input bit typed = 0, input tdrmq_pkg::rsp_type result = '0);
      directed[n].kind    = kind;
      directed[n].beat    = r;
      directed[n].csr_idx = idx;
      directed[n].csr_val = v;
      directed[n].typed   = typed;
      directed[n].result  = result;
      n++;
   endtask

   task automatic build_directed;
      int n;
      n = 0;
      // After reset no vertex is valid and the reset marker comes back.
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 0, 0, 0), 0, 0, 1,
              {tdrmq_pkg::UnreachReset, 1'b1});
      add_row(n, ROW_CSR, '0, tdrmq_pkg::CSR_VERTEX_COUNT, 31'd1024);
      add_row(n, ROW_CSR, '0, tdrmq_pkg::CSR_UNREACHABLE, DEPTH_MAX);
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 0, 0, 31'h7FFF_FFFE));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 1, 0, 0));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 2, 0, 31'h7FFF_FFFE));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 3, 0, DEPTH_MAX));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_POS, 0, 0, 0));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_POS, 1, 2, 0));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_POS, 2, 1, 0));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_POS, 3, 3, 0));
      // Both ends near the top with a zero between: the sum saturates.
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 0, 1, 0), 0, 0, 1,
              {DEPTH_MAX, 1'b0});
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 0, 2, 0), 0, 0, 1,
              {31'h7FFF_FFFE, 1'b0});
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 2, 2, 0), 0, 0, 1,
              {31'd0, 1'b0});
      // Vertex 3 sits on a slot holding the marker, so it is not in the tree.
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 3, 0, 0), 0, 0, 1,
              {DEPTH_MAX, 1'b1});
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 1024, 0, 0), 0, 0, 1,
              {DEPTH_MAX, 1'b1});
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 0, 2047, 0), 0, 0, 1,
              {DEPTH_MAX, 1'b1});
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_UNUSED, 2047, 2047, DEPTH_MAX));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_POS, 2047, 2047, 0));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 2047, 0, 31'd5));
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_LOAD_POS, 1023, 2047, 0));
      // The last tour slot against itself.
      add_row(n, ROW_BEAT, make_beat(tdrmq_pkg::ACT_QUERY, 1023, 1023, 0));
   endtask

   function automatic logic [10:0] pick_vertex(input logic [10:0] pool[$]);
      if (pool.size() == 0 || $urandom_range(0, 9) == 0) return 11'($urandom_range(0, 2047));
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   task automatic random_phase(input int phase, inout int counted);
      logic [10:0] members[$];
      logic [30:0] level;
      logic [10:0] a, b, first_slot, vtx;
      int tour_len, queries;
      bit found;

      case (phase % 4)
         0: write_reg(tdrmq_pkg::CSR_VERTEX_COUNT, 31'd1024);
         1: write_reg(tdrmq_pkg::CSR_VERTEX_COUNT, 31'($urandom_range(1, 1024)));
         2: write_reg(tdrmq_pkg::CSR_VERTEX_COUNT, (phase % 8 == 2) ? 31'd0 : 31'd1024);
         default: write_reg(tdrmq_pkg::CSR_VERTEX_COUNT, 31'($urandom_range(0, 2047)));
      endcase
      case ($urandom_range(0, 3))
         0: write_reg(tdrmq_pkg::CSR_UNREACHABLE, DEPTH_MAX);
         1: write_reg(tdrmq_pkg::CSR_UNREACHABLE, 31'd0);
         2: write_reg(tdrmq_pkg::CSR_UNREACHABLE, 31'($urandom_range(0, 12)));
         default: write_reg(tdrmq_pkg::CSR_UNREACHABLE, 31'($urandom) & DEPTH_MAX);
      endcase
      idle_on = (phase % 5 != 3);

      // A tour as a walk of depths over a run of consecutive slots.
      tour_len   = $urandom_range(4, 40);
      first_slot = 11'($urandom_range(0, tdrmq_pkg::TourLength - tour_len));
      level = $urandom_range(0, 1) ? 31'($urandom_range(0, 6))
                                   : 31'(DEPTH_MAX - $urandom_range(0, 60));
      for (int i = 0; i < tour_len; i++) begin
         send_beat(make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 11'(first_slot + i), 11'($urandom),
                             level));
         counted++;
         if ($urandom_range(0, 1) && level < DEPTH_MAX) level++;
         else if (level > 0) level--;
         if ($urandom_range(0, 7) == 0)
            send_beat(make_beat(tdrmq_pkg::ACT_UNUSED, 11'($urandom), 11'($urandom),
                                31'($urandom)));
      end
      repeat ($urandom_range(3, 12)) begin
         vtx = 11'($urandom_range(0, 1023));
         if (vertex_limit > 0 && $urandom_range(0, 3) != 0)
            vtx = 11'($urandom_range(0, (vertex_limit > 1024 ? 1024 : vertex_limit) - 1));
         members = {members, vtx};
         send_beat(make_beat(tdrmq_pkg::ACT_LOAD_POS, vtx,
                             11'(first_slot + $urandom_range(0, tour_len - 1)),
                             31'($urandom)));
         counted++;
      end

      queries = $urandom_range(20, 50);
      for (int q = 0; q < queries; q++) begin
         case ($urandom_range(0, 9))
            0: send_beat(make_beat(tdrmq_pkg::ACT_LOAD_DEPTH, 11'($urandom), 11'($urandom),
                                   31'($urandom)));
            1: send_beat(make_beat(tdrmq_pkg::ACT_LOAD_POS, 11'($urandom), 11'($urandom),
                                   31'($urandom)));
            2: send_beat(make_beat(tdrmq_pkg::ACT_UNUSED, 11'($urandom), 11'($urandom),
                                   31'($urandom)));
            default: begin
               found = 0;
               for (int t = 0; t < 8 && !found; t++) begin
                  a = pick_vertex(members);
                  b = pick_vertex(members);
                  found = query_is_defined(a, b);
               end
               if (!found) begin
                  a = 11'd2047;
                  b = 11'($urandom);
               end
               send_beat(make_beat(tdrmq_pkg::ACT_QUERY, a, b, 31'($urandom)));
            end
         endcase
         counted++;
         // Once in the run the sender holds off until every result is back.
         if (phase == 1 && q == queries / 2) drain();
      end
   endtask

   initial begin
      int counted, phase;
      error_count = 0;
      idle_on     = 1;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_write   = 1'b0;
      csr_index   = 1'b0;
      csr_data    = '0;
      vertex_limit = '0;
      marker       = tdrmq_pkg::UnreachReset;
      for (int i = 0; i < tdrmq_pkg::TourLength; i++) begin
         depth_mem[i] = '0;
         depth_set[i] = 0;
      end
      for (int i = 0; i < tdrmq_pkg::MaxVertices; i++) begin
         pos_mem[i] = '0;
         pos_set[i] = 0;
      end
      build_directed();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed[i].kind == ROW_CSR) write_reg(directed[i].csr_idx, directed[i].csr_val);
         else send_beat(directed[i].beat, directed[i].typed, directed[i].result);
      end

      counted = 0;
      phase = 0;
      while (counted < RANDOM_ITEMS) begin
         random_phase(phase, counted);
         phase++;
      end

      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0 && pending_distances.size() == 0) begin
         $display("tree_distance_range_min_query_core test passed");
      end else begin
         $display("tree_distance_range_min_query_core test failed");
      end
      $finish;
   end
endmodule
